### src/shfx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// shfx_pkg
// Shared constants and controller/datapath handshake types for the sync header
// framer with XOR checksum.
// -----------------------------------------------------------------------------
package shfx_pkg;

	// Sync header, first byte at index 0
	localparam logic [3:0][7:0] SYNC_HDR = {8'hDD, 8'hCC, 8'hBB, 8'hAA};
	localparam int HDR_LEN = 4;

	// Controller to datapath
	typedef struct packed {
		logic clear_frame;   // header complete: restart count, checksum, assembly
		logic take_payload;  // accepted request is a payload byte
		logic start_dump;    // checksum good: read out the stored words
		logic send_error;    // checksum bad: load the error result
	} shfx_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [HDR_LEN-1:0] hdr_hit;  // incoming byte equals header byte i
		logic               last_byte; // this payload byte fills the frame
		logic               xor_match; // incoming byte equals running checksum
		logic               out_free;  // result register can take a new result
		logic               dump_done; // final word moved into result register
	} shfx_status_t;

endpackage
`default_nettype wire

### src/shfx_if.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// shfx_if
// Valid/ready channels: received bytes in, frame results out.
// -----------------------------------------------------------------------------
interface shfx_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source(output valid, output rx_byte, input ready);
	modport sink(input valid, input rx_byte, output ready);
endinterface

interface shfx_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] payload_word;
	logic [4:0]  word_index;
	logic        frame_status;
	logic        last_of_frame;

	modport source(output valid, output payload_word, output word_index,
		output frame_status, output last_of_frame, input ready);
	modport sink(input valid, input payload_word, input word_index,
		input frame_status, input last_of_frame, output ready);
endinterface
`default_nettype wire

### src/shfx_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// shfx_ram
// Generic single-write, single-read RAM with registered read data.
// -----------------------------------------------------------------------------
module shfx_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 21,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// hold read data when no read is issued
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

### src/shfx_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// shfx_dp
// Datapath: checksum, word assembly, payload store, readout and result register.
// -----------------------------------------------------------------------------
module shfx_dp
	import shfx_pkg::*;
#(
	parameter int PAYLOAD_WORDS = 21
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [7:0]   rx_byte,
	input  shfx_cmd_t    cmd,
	output shfx_status_t status,
	input  logic         out_ready,
	output logic         out_valid,
	output logic [31:0]  payload_word,
	output logic [4:0]   word_index,
	output logic         frame_status,
	output logic         last_of_frame
);

	localparam int CW = $clog2(4 * PAYLOAD_WORDS + 1);
	localparam int AW = (PAYLOAD_WORDS > 1) ? $clog2(PAYLOAD_WORDS) : 1;
	localparam int RW = $clog2(PAYLOAD_WORDS + 1);
	localparam logic [CW-1:0] LAST_BYTE = CW'(4 * PAYLOAD_WORDS - 1);
	localparam logic [RW-1:0] LAST_WORD = RW'(PAYLOAD_WORDS - 1);

	logic [CW-1:0] count_q;
	logic [7:0]    xor_q;
	logic [31:0]   asm_q;
	logic [31:0]   asm_next;
	logic          wr_en;
	logic [AW-1:0] wr_addr;

	logic [RW-1:0] rd_idx_q;
	logic          dumping_q;
	logic          pend_s1;
	logic [RW-1:0] idx_s1;
	logic          issue;
	logic          load;
	logic [31:0]   rd_data;

	logic          out_valid_q;
	logic [31:0]   word_q;
	logic [4:0]    index_q;
	logic          status_q;
	logic          last_q;

	assign asm_next = {rx_byte, asm_q[31:8]};
	// a word completes on every fourth payload byte
	assign wr_en    = cmd.take_payload && (count_q[1:0] == 2'd3);
	assign wr_addr  = AW'(count_q >> 2);

	assign load  = pend_s1 && (!out_valid_q || out_ready);
	assign issue = dumping_q && (!pend_s1 || load);

	always_comb begin
		for (int i = 0; i < HDR_LEN; i++) begin
			status.hdr_hit[i] = (rx_byte == SYNC_HDR[i]);
		end
		status.last_byte = (count_q == LAST_BYTE);
		status.xor_match = (rx_byte == xor_q);
		status.out_free  = !out_valid_q || out_ready;
		status.dump_done = load && (idx_s1 == LAST_WORD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			xor_q   <= '0;
			asm_q   <= '0;
		end else if (cmd.clear_frame) begin
			count_q <= '0;
			xor_q   <= '0;
			asm_q   <= '0;
		end else if (cmd.take_payload) begin
			count_q <= count_q + 1'b1;
			xor_q   <= xor_q ^ rx_byte;
			asm_q   <= asm_next;
		end
	end

	shfx_ram #(
		.WIDTH(32),
		.DEPTH(PAYLOAD_WORDS)
	) u_store (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(asm_next),
		.re   (issue),
		.raddr(rd_idx_q[AW-1:0]),
		.rdata(rd_data)
	);

	// readout: one read in flight, refilled as the result register drains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q  <= '0;
			dumping_q <= 1'b0;
			pend_s1   <= 1'b0;
		end else begin
			if (cmd.start_dump) begin
				rd_idx_q  <= '0;
				dumping_q <= 1'b1;
			end else if (issue) begin
				rd_idx_q <= rd_idx_q + 1'b1;
				if (rd_idx_q == LAST_WORD) begin
					dumping_q <= 1'b0;
				end
			end
			if (issue) begin
				pend_s1 <= 1'b1;
			end else if (load) begin
				pend_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			idx_s1 <= rd_idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load || cmd.send_error) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_q   <= rd_data;
			index_q  <= 5'(idx_s1);
			status_q <= 1'b0;
			last_q   <= (idx_s1 == LAST_WORD);
		end else if (cmd.send_error) begin
			word_q   <= '0;
			index_q  <= '0;
			status_q <= 1'b1;
			last_q   <= 1'b1;
		end
	end

	assign out_valid     = out_valid_q;
	assign payload_word  = word_q;
	assign word_index    = index_q;
	assign frame_status  = status_q;
	assign last_of_frame = last_q;

endmodule
`default_nettype wire

### src/shfx_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// shfx_ctrl
// Controller: header hunt, payload/checksum phases and readout sequencing.
// -----------------------------------------------------------------------------
module shfx_ctrl
	import shfx_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  shfx_status_t status,
	output shfx_cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_HUNT,
		ST_PAYLOAD,
		ST_CHECK,
		ST_DUMP
	} state_t;

	state_t      state_q;
	logic [1:0]  hdr_cnt_q;
	logic        accept;

	always_comb begin
		case (state_q)
			ST_HUNT:    in_ready = 1'b1;
			ST_PAYLOAD: in_ready = 1'b1;
			ST_CHECK:   in_ready = status.out_free;
			ST_DUMP:    in_ready = 1'b0;
			default:    in_ready = 1'b0;
		endcase
	end

	assign accept = in_valid && in_ready;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_HUNT: begin
				cmd.clear_frame = accept && (hdr_cnt_q == 2'd3) && status.hdr_hit[3];
			end
			ST_PAYLOAD: begin
				cmd.take_payload = accept;
			end
			ST_CHECK: begin
				cmd.start_dump = accept && status.xor_match;
				cmd.send_error = accept && !status.xor_match;
			end
			ST_DUMP: begin
				cmd = '0;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_HUNT;
			hdr_cnt_q <= '0;
		end else begin
			case (state_q)
				ST_HUNT: begin
					if (accept) begin
						if (status.hdr_hit[hdr_cnt_q]) begin
							if (hdr_cnt_q == 2'd3) begin
								hdr_cnt_q <= '0;
								state_q   <= ST_PAYLOAD;
							end else begin
								hdr_cnt_q <= hdr_cnt_q + 1'b1;
							end
						end else begin
							// restart the match, counting a fresh first header byte
							hdr_cnt_q <= status.hdr_hit[0] ? 2'd1 : 2'd0;
						end
					end
				end
				ST_PAYLOAD: begin
					if (accept && status.last_byte) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (accept) begin
						hdr_cnt_q <= '0;
						state_q   <= status.xor_match ? ST_DUMP : ST_HUNT;
					end
				end
				ST_DUMP: begin
					if (status.dump_done) begin
						state_q <= ST_HUNT;
					end
				end
				default: begin
					state_q   <= ST_HUNT;
					hdr_cnt_q <= '0;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

### src/sync_header_frame_xor_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// sync_header_frame_xor_checker
// Hunts for the AA BB CC DD sync header, stores the following payload words,
// checks the XOR checksum byte and emits the frame words or one error result.
// -----------------------------------------------------------------------------
//  channel | dir | fields
//  rx      | in  | rx_byte[7:0]
//  res     | out | payload_word[31:0], word_index[4:0], frame_status, last_of_frame
//
//  Header and payload bytes are taken one per cycle.
//  A good checksum starts a readout of PAYLOAD_WORDS results from the payload
//  RAM at one per cycle while the result channel is ready; no byte is taken
//  until the last word is in the result register.
//  The checksum byte waits for a free result register; a bad one then loads
//  the error.
//  Reset clears all control state; the payload RAM needs no clearing.
// -----------------------------------------------------------------------------
module sync_header_frame_xor_checker
	import shfx_pkg::*;
#(
	parameter int PAYLOAD_WORDS = 21
) (
	input  logic                  clk,
	input  logic                  arst_n,
	shfx_byte_if.sink             rx,
	shfx_result_if.source         res
);

	shfx_cmd_t    cmd;
	shfx_status_t status;

	shfx_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(rx.valid),
		.in_ready(rx.ready),
		.status  (status),
		.cmd     (cmd)
	);

	shfx_dp #(
		.PAYLOAD_WORDS(PAYLOAD_WORDS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx_byte      (rx.rx_byte),
		.cmd          (cmd),
		.status       (status),
		.out_ready    (res.ready),
		.out_valid    (res.valid),
		.payload_word (res.payload_word),
		.word_index   (res.word_index),
		.frame_status (res.frame_status),
		.last_of_frame(res.last_of_frame)
	);

endmodule
`default_nettype wire
